### rtl/lsv_pkg.sv
// Shared types, constants and codes for the landblock stream validator.
package lsv_pkg;

  localparam int HEADER_BYTES = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int SIDE_W = 11;
  localparam int LAYER_W = 4;
  localparam int CELL_W = 2 * SIDE_W - 1;
  localparam int EXP_LEN_W = CELL_W + 5;
  localparam int HEIGHT_W = CELL_W + 2;
  localparam int ADDR_W = 5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MAGIC = 3'd0;
  localparam logic [2:0] REG_VERSION = 3'd1;
  localparam logic [2:0] REG_MIN_SIDE = 3'd2;
  localparam logic [2:0] REG_MAX_SIDE = 3'd3;
  localparam logic [2:0] REG_MAX_LAYERS = 3'd4;

  // Header word positions.
  localparam logic [2:0] HW_MAGIC = 3'd0;
  localparam logic [2:0] HW_VERSION = 3'd1;
  localparam logic [2:0] HW_ID = 3'd2;
  localparam logic [2:0] HW_SIDE = 3'd3;
  localparam logic [2:0] HW_LAYERS = 3'd4;
  localparam logic [2:0] HW_FLAGS = 3'd5;
  localparam logic [2:0] HW_RES0 = 3'd6;
  localparam logic [2:0] HW_RES1 = 3'd7;

  localparam logic [15:0] ID_LOW_MASK = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SMALL     = 4'd1,
    ST_MAGIC     = 4'd2,
    ST_VERSION   = 4'd3,
    ST_SIDE      = 4'd4,
    ST_LAYERS    = 4'd5,
    ST_FLAGS     = 4'd6,
    ST_RESERVED  = 4'd7,
    ST_SIZE      = 4'd8,
    ST_NONFINITE = 4'd9,
    ST_ID        = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_HDR   = 2'd1,
    K_LANE2 = 2'd2,
    K_LANE3 = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        last;
    logic [31:0] pos;
    logic [31:0] word;
  } entry_t;

  typedef struct packed {
    logic [31:0]        magic_word;
    logic [31:0]        format_version;
    logic [SIDE_W-1:0]  min_side;
    logic [SIDE_W-1:0]  max_side;
    logic [LAYER_W-1:0] max_layers;
  } cfg_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer_count;
    logic [SIDE_W-1:0]  side_count;
    logic [31:0]        block_id;
    status_t            status;
  } result_t;

endpackage

### rtl/lsv_regs.sv
// Configuration register file behind the APB-style port.
module lsv_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output lsv_pkg::cfg_t             cfg
);
  import lsv_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word <= 32'd0;
      cfg.format_version <= 32'd1;
      cfg.min_side <= SIDE_W'(2);
      cfg.max_side <= SIDE_W'(255);
      cfg.max_layers <= LAYER_W'(8);
    end else if (wr) begin
      case (idx)
        REG_MAGIC: cfg.magic_word <= pwdata;
        REG_VERSION: cfg.format_version <= pwdata;
        REG_MIN_SIDE: cfg.min_side <= pwdata[SIDE_W-1:0];
        REG_MAX_SIDE: cfg.max_side <= pwdata[SIDE_W-1:0];
        REG_MAX_LAYERS: cfg.max_layers <= pwdata[LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAGIC: prdata = cfg.magic_word;
      REG_VERSION: prdata = cfg.format_version;
      REG_MIN_SIDE: prdata = {{(32-SIDE_W){1'b0}}, cfg.min_side};
      REG_MAX_SIDE: prdata = {{(32-SIDE_W){1'b0}}, cfg.max_side};
      REG_MAX_LAYERS: prdata = {{(32-LAYER_W){1'b0}}, cfg.max_layers};
      default: prdata = 32'd0;
    endcase
  end

endmodule

### rtl/lsv_front.sv
// Front end: takes bytes, assembles words, counts position and classifies.
module lsv_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] byte_value
  input  logic            s_tlast,
  input  logic            q_full,
  output logic            q_push,
  output lsv_pkg::entry_t q_entry
);
  import lsv_pkg::*;

  logic [31:0] word_shift;
  logic [31:0] byte_count;
  logic [31:0] word_next;
  logic        accept;
  logic        in_header;
  kind_t       kind;

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;
  assign word_next = {s_tdata, word_shift[31:8]};
  assign in_header = (byte_count < 32'(HEADER_BYTES));

  always_comb begin
    kind = K_NONE;
    if (in_header) begin
      if (byte_count[1:0] == 2'd3) kind = K_HDR;
    end else begin
      case (byte_count[1:0])
        2'd2: kind = K_LANE2;
        2'd3: kind = K_LANE3;
        default: kind = K_NONE;
      endcase
    end
  end

  assign q_push = accept && ((kind != K_NONE) || s_tlast);
  assign q_entry = '{kind: kind, last: s_tlast, pos: byte_count, word: word_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      word_shift <= 32'd0;
      byte_count <= 32'd0;
    end else if (accept) begin
      if (s_tlast) begin
        word_shift <= 32'd0;
        byte_count <= 32'd0;
      end else begin
        word_shift <= word_next;
        if (byte_count != 32'hFFFF_FFFF) byte_count <= byte_count + 32'd1;
      end
    end
  end

endmodule

### rtl/lsv_queue.sv
// Short queue of classified items between the front and the back end.
module lsv_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lsv_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output lsv_pkg::entry_t head
);
  import lsv_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && head_valid) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !full, pop && head_valid})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count above depth");

endmodule

### rtl/lsv_back.sv
// Back end: header checks, size products, height scan and the result register.
module lsv_back (
  input  logic             clk,
  input  logic             rst,
  input  lsv_pkg::cfg_t    cfg,
  input  logic             head_valid,
  input  lsv_pkg::entry_t  head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output lsv_pkg::result_t result
);
  import lsv_pkg::*;

  status_t              header_error, header_error_next;
  logic [SIDE_W-1:0]    side_reg, side_reg_next;
  logic [LAYER_W-1:0]   layers_reg, layers_reg_next;
  logic [31:0]          id_reg, id_reg_next;
  logic                 nonfinite_seen, nonfinite_next;
  logic                 exp_bit, exp_bit_next;
  logic [CELL_W-1:0]    cells;
  logic [EXP_LEN_W-1:0] expected_len;
  logic [HEIGHT_W-1:0]  height_end;
  logic [2*SIDE_W-1:0]  side_sq;
  logic [EXP_LEN_W-1:0] len_prod;
  logic [31:0]          length;
  logic [31:0]          w;
  logic                 in_height;
  status_t              st;
  result_t              result_next;

  function automatic status_t flag(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  assign pop = head_valid && (!head.last || !m_tvalid || m_tready);
  assign w = head.word;
  assign in_height = (head.pos < {{(32-HEIGHT_W){1'b0}}, height_end});
  assign length = (head.pos == 32'hFFFF_FFFF) ? head.pos : head.pos + 32'd1;

  // The size products run freely; side settles at header word three and layers at word four,
  // at least three queue entries before any result or height byte uses them.
  assign side_sq = {{SIDE_W{1'b0}}, side_reg} * {{SIDE_W{1'b0}}, side_reg};
  assign len_prod = {5'd0, cells} * {{(EXP_LEN_W-5){1'b0}}, 5'(layers_reg) + 5'd4};

  always_ff @(posedge clk) begin
    cells <= side_sq[CELL_W-1:0];
    expected_len <= len_prod + EXP_LEN_W'(HEADER_BYTES);
    height_end <= {cells, 2'b00} + HEIGHT_W'(HEADER_BYTES);
  end

  always_comb begin
    header_error_next = header_error;
    side_reg_next = side_reg;
    layers_reg_next = layers_reg;
    id_reg_next = id_reg;
    nonfinite_next = nonfinite_seen;
    exp_bit_next = exp_bit;
    st = ST_OK;
    result_next = result;
    if (pop) begin
      case (head.kind)
        K_HDR: begin
          case (head.pos[4:2])
            HW_MAGIC: if (w != cfg.magic_word)
              header_error_next = flag(header_error_next, ST_MAGIC);
            HW_VERSION: if (w != cfg.format_version)
              header_error_next = flag(header_error_next, ST_VERSION);
            HW_ID: id_reg_next = w;
            HW_SIDE: begin
              if (w < {21'd0, cfg.min_side} || w > {21'd0, cfg.max_side})
                header_error_next = flag(header_error_next, ST_SIDE);
              else
                side_reg_next = w[SIDE_W-1:0];
            end
            HW_LAYERS: begin
              if (w > {28'd0, cfg.max_layers})
                header_error_next = flag(header_error_next, ST_LAYERS);
              else
                layers_reg_next = w[LAYER_W-1:0];
            end
            HW_FLAGS: if (w != 32'd0)
              header_error_next = flag(header_error_next, ST_FLAGS);
            HW_RES0: if (w != 32'd0)
              header_error_next = flag(header_error_next, ST_RESERVED);
            HW_RES1: begin
              if (w != 32'd0)
                header_error_next = flag(header_error_next, ST_RESERVED);
              if ((id_reg[15:0] & ID_LOW_MASK) != 16'd0)
                header_error_next = flag(header_error_next, ST_ID);
            end
            default: ;
          endcase
        end
        K_LANE2: if (header_error == ST_OK && in_height) exp_bit_next = w[31];
        K_LANE3: begin
          // The top byte of a height word holds the sign and exponent bits 30..24.
          if (header_error == ST_OK && in_height && w[30:24] == 7'h7F && exp_bit)
            nonfinite_next = 1'b1;
        end
        default: ;
      endcase

      if (head.last) begin
        if (length < 32'(HEADER_BYTES)) st = ST_SMALL;
        else if (header_error_next != ST_OK) st = header_error_next;
        else if (length != {{(32-EXP_LEN_W){1'b0}}, expected_len}) st = ST_SIZE;
        else if (nonfinite_next) st = ST_NONFINITE;
        else st = ST_OK;
        result_next.status = st;
        result_next.block_id = (st == ST_OK) ? id_reg_next : 32'd0;
        result_next.side_count = (st == ST_OK) ? side_reg_next : '0;
        result_next.layer_count = (st == ST_OK) ? layers_reg_next : '0;
        header_error_next = ST_OK;
        side_reg_next = '0;
        layers_reg_next = '0;
        id_reg_next = 32'd0;
        nonfinite_next = 1'b0;
        exp_bit_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_error <= ST_OK;
      side_reg <= '0;
      layers_reg <= '0;
      id_reg <= 32'd0;
      nonfinite_seen <= 1'b0;
      exp_bit <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      header_error <= header_error_next;
      side_reg <= side_reg_next;
      layers_reg <= layers_reg_next;
      id_reg <= id_reg_next;
      nonfinite_seen <= nonfinite_next;
      exp_bit <= exp_bit_next;
      if (pop && head.last) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.status != ST_OK) |->
      (result.block_id == 32'd0 && result.side_count == '0 && result.layer_count == '0))
    else $error("failed result carries payload");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (header_error == ST_OK && !nonfinite_seen && id_reg == 32'd0))
    else $error("stream state not cleared after final byte");

  a_nonfinite_clean_hdr: assert property (@(posedge clk) disable iff (rst)
    nonfinite_seen |-> (header_error == ST_OK))
    else $error("nonfinite mark with a header error");

endmodule

### rtl/landblock_stream_validator_top.sv
// Top level of the landblock stream validator: registers, front, queue and back.
// Throughput: one byte per cycle; the front stalls only while the four-entry queue is full.
// Result path: after the final byte's transfer, the result passes the queue and then
// the result register in the back end.
// Reset: synchronous, active high; clears the stream state and the queue and loads
// the configuration registers with their default values.
module landblock_stream_validator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] byte_value
  input  logic                       s_tlast,   // last_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [55:0]                m_tdata,   // [3:0] status, [35:4] block_id,
                                                // [46:36] side_count, [50:47] layer_count
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lsv_pkg::*;

  cfg_t    cfg;
  entry_t  push_entry;
  entry_t  head;
  logic    push;
  logic    full;
  logic    head_valid;
  logic    pop;
  result_t result;

  lsv_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  lsv_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tlast(s_tlast), .q_full(full), .q_push(push),
    .q_entry(push_entry)
  );

  lsv_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry), .pop(pop),
    .full(full), .head_valid(head_valid), .head(head)
  );

  lsv_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head_valid(head_valid), .head(head),
    .pop(pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .result(result)
  );

  assign m_tdata = {5'd0, result};

endmodule

### tb/testbench.sv
// Self-checking testbench for the landblock stream validator: directed images, then random ones.
`timescale 1ns / 100ps

module testbench;
  import lsv_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 6;

  typedef enum int {
    BRK_MAGIC, BRK_VERSION, BRK_SIDE_LOW, BRK_SIDE_HIGH, BRK_SIDE_WIDE, BRK_LAYERS,
    BRK_FLAGS, BRK_RES0, BRK_RES1, BRK_ID, BRK_LONG, BRK_SHORT, BRK_TINY, BRK_NOISE
  } breakage_t;

  typedef struct {
    cfg_t             cfg;
    logic [7:0][31:0] hdr;
    int               len;      // zero means the length that the header calls for
    int               len_adj;
    int               nf_cell;  // height cell made nonfinite, or -1
    bit               typed;
    status_t          st;
  } image_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [55:0]         m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Predicted validator state and the register values the block holds.
  cfg_t                cur_cfg;
  logic [31:0]         asm_word;
  logic [31:0]         seen_bytes;
  logic [31:0]         acc_id;
  logic [31:0]         want_len;
  status_t             hdr_fault;
  logic [SIDE_W-1:0]   acc_side;
  logic [LAYER_W-1:0]  acc_layers;
  logic                bad_height;
  logic                exp_lsb;

  result_t             verdict_q[$];
  image_row_t          image_rows[$];
  int                  mismatches;
  int                  bytes_sent;
  int                  cycles;
  int                  send_idle;
  int                  recv_stall;

  landblock_stream_validator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, verdict_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  function automatic cfg_t make_cfg(input logic [31:0] magic, input logic [31:0] version,
                                    input int min_s, input int max_s, input int layers);
    cfg_t c;
    c.magic_word = magic;
    c.format_version = version;
    c.min_side = SIDE_W'(min_s);
    c.max_side = SIDE_W'(max_s);
    c.max_layers = LAYER_W'(layers);
    return c;
  endfunction

  function automatic logic [7:0][31:0] pack_header(
      input logic [31:0] magic, input logic [31:0] version, input logic [31:0] id,
      input logic [31:0] side, input logic [31:0] layers, input logic [31:0] flags,
      input logic [31:0] res0, input logic [31:0] res1);
    return {res1, res0, flags, layers, side, id, version, magic};
  endfunction

  function automatic void add_row(input cfg_t cfg, input logic [7:0][31:0] hdr, input int len,
                                  input int len_adj, input int nf_cell, input bit typed,
                                  input status_t st);
    image_row_t row;
    row.cfg = cfg;
    row.hdr = hdr;
    row.len = len;
    row.len_adj = len_adj;
    row.nf_cell = nf_cell;
    row.typed = typed;
    row.st = st;
    image_rows.push_back(row);
  endfunction

  function automatic void clear_scan();
    asm_word = '0;
    seen_bytes = '0;
    acc_id = '0;
    want_len = '0;
    hdr_fault = ST_OK;
    acc_side = '0;
    acc_layers = '0;
    bad_height = 1'b0;
    exp_lsb = 1'b0;
  endfunction

  function automatic void flag_fault(input status_t code);
    if (hdr_fault == ST_OK) hdr_fault = code;
  endfunction

  // Takes one byte of the image; returns 1 with the verdict when the byte is the final one.
  function automatic bit scan_byte(input logic [7:0] b, input bit last, output result_t r);
    logic [31:0] pos;
    logic [31:0] side32;
    status_t     st;
    pos = seen_bytes;
    side32 = {21'd0, acc_side};
    asm_word = {b, asm_word[31:8]};
    r = '0;
    if (pos < HEADER_BYTES) begin
      if (pos[1:0] == 2'd3) begin
        case (pos[4:2])
          HW_MAGIC: if (asm_word != cur_cfg.magic_word) flag_fault(ST_MAGIC);
          HW_VERSION: if (asm_word != cur_cfg.format_version) flag_fault(ST_VERSION);
          HW_ID: acc_id = asm_word;
          HW_SIDE: begin
            if (asm_word < {21'd0, cur_cfg.min_side} || asm_word > {21'd0, cur_cfg.max_side})
              flag_fault(ST_SIDE);
            else acc_side = asm_word[SIDE_W-1:0];
          end
          HW_LAYERS: begin
            if (asm_word > {28'd0, cur_cfg.max_layers}) flag_fault(ST_LAYERS);
            else acc_layers = asm_word[LAYER_W-1:0];
          end
          HW_FLAGS: if (asm_word != 32'd0) flag_fault(ST_FLAGS);
          HW_RES0: if (asm_word != 32'd0) flag_fault(ST_RESERVED);
          default: begin
            if (asm_word != 32'd0) flag_fault(ST_RESERVED);
            if (acc_id[15:0] != 16'd0) flag_fault(ST_ID);
            if (hdr_fault == ST_OK)
              want_len = HEADER_BYTES + side32 * side32 * (32'd4 + {28'd0, acc_layers});
          end
        endcase
      end
    end else if (hdr_fault == ST_OK) begin
      // Height words: bit 23 arrives in lane two, bits 30..24 in lane three.
      if (pos < HEADER_BYTES + 32'd4 * side32 * side32) begin
        if (pos[1:0] == 2'd2) exp_lsb = b[7];
        else if (pos[1:0] == 2'd3 && b[6:0] == 7'h7F && exp_lsb) bad_height = 1'b1;
      end
    end
    if (seen_bytes != 32'hFFFF_FFFF) seen_bytes = seen_bytes + 32'd1;
    if (!last) return 1'b0;
    if (seen_bytes < HEADER_BYTES) st = ST_SMALL;
    else if (hdr_fault != ST_OK) st = hdr_fault;
    else if (seen_bytes != want_len) st = ST_SIZE;
    else if (bad_height) st = ST_NONFINITE;
    else st = ST_OK;
    r.status = st;
    if (st == ST_OK) begin
      r.block_id = acc_id;
      r.side_count = acc_side;
      r.layer_count = acc_layers;
    end
    clear_scan();
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch in %s: got 0x%0h, want 0x%0h", what, got, want);
  endtask

  always @(negedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[50:0]);
      if (verdict_q.size() == 0) begin
        note_mismatch("result with none pending", m_tdata[31:0], 32'd0);
      end else begin
        want = verdict_q.pop_front();
        if (got.status != want.status)
          note_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.block_id != want.block_id) note_mismatch("block_id", got.block_id, want.block_id);
        if (got.side_count != want.side_count)
          note_mismatch("side_count", 32'(got.side_count), 32'(want.side_count));
        if (got.layer_count != want.layer_count)
          note_mismatch("layer_count", 32'(got.layer_count), 32'(want.layer_count));
      end
    end
  end

  // The transfer happens at the edge after a negedge that saw tready high.
  task automatic push_byte(input logic [7:0] b, input bit last, input bit typed,
                           input result_t typed_res);
    bit      took;
    result_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end
    bytes_sent++;
    if (scan_byte(b, last, r)) verdict_q.push_back(typed ? typed_res : r);
  endtask

  task automatic send_image(input logic [7:0][31:0] h, input int total, input int nf_cell,
                            input bit typed, input status_t want_st);
    int          side;
    int          cells;
    int          height_end;
    logic [31:0] height;
    logic [7:0]  b;
    result_t     tr;
    side = (h[HW_SIDE] <= 32'd2048) ? int'(h[HW_SIDE]) : 0;
    cells = side * side;
    height_end = HEADER_BYTES + 4 * cells;
    height = '0;
    tr = '0;
    tr.status = want_st;
    if (want_st == ST_OK) begin
      tr.block_id = h[HW_ID];
      tr.side_count = h[HW_SIDE][SIDE_W-1:0];
      tr.layer_count = h[HW_LAYERS][LAYER_W-1:0];
    end
    for (int p = 0; p < total; p++) begin
      if (p < HEADER_BYTES) begin
        b = h[p / 4][8 * (p % 4) +: 8];
      end else if (p < height_end) begin
        if (p % 4 == 0) begin
          height = $urandom;
          if ((p - HEADER_BYTES) / 4 == nf_cell) height[30:23] = 8'hFF;
          else if (height[30:23] == 8'hFF) height[30] = 1'b0;
        end
        b = height[8 * (p % 4) +: 8];
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      push_byte(b, p == total - 1, typed, tr);
    end
  endtask

  task automatic random_image();
    int               lo;
    int               hi;
    int               s;
    int               l;
    int               total;
    int               nf_cell;
    int               pick;
    int               bitn;
    logic [7:0][31:0] h;
    lo = int'(cur_cfg.min_side);
    hi = int'(cur_cfg.max_side);
    if (hi > lo + 2) hi = lo + 2;
    s = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(1, 8);
    l = $urandom_range(0, cur_cfg.max_layers);
    h = pack_header(cur_cfg.magic_word, cur_cfg.format_version,
                    {16'($urandom_range(0, 65535)), 16'h0000}, s, l, 0, 0, 0);
    // Large sides are only ever sent as a header and a short tail.
    total = (s <= 4) ? HEADER_BYTES + s * s * (4 + l) : HEADER_BYTES + $urandom_range(0, 48);
    nf_cell = -1;
    bitn = $urandom_range(0, 31);
    pick = $urandom_range(0, 99);
    if (pick < 10 && s <= 4) begin
      nf_cell = $urandom_range(0, s * s - 1);
    end else if (pick >= 62) begin
      case (breakage_t'($urandom_range(0, int'(BRK_NOISE))))
        BRK_MAGIC: h[HW_MAGIC][bitn] = ~h[HW_MAGIC][bitn];
        BRK_VERSION: h[HW_VERSION][bitn] = ~h[HW_VERSION][bitn];
        BRK_SIDE_LOW: h[HW_SIDE] = lo - 1;
        BRK_SIDE_HIGH: h[HW_SIDE] = cur_cfg.max_side + $urandom_range(1, 3);
        BRK_SIDE_WIDE: h[HW_SIDE] = $urandom | 32'h8000_0000;
        BRK_LAYERS: h[HW_LAYERS] = cur_cfg.max_layers + $urandom_range(1, 20);
        BRK_FLAGS: h[HW_FLAGS] = 32'd1 << bitn;
        BRK_RES0: h[HW_RES0] = 32'd1 << bitn;
        BRK_RES1: h[HW_RES1] = 32'd1 << bitn;
        BRK_ID: h[HW_ID][15:0] = 16'($urandom_range(1, 65535));
        BRK_LONG: total = total + $urandom_range(1, 6);
        BRK_SHORT: begin
          total = total - $urandom_range(1, 6);
          if (total < 1) total = 1;
        end
        BRK_TINY: total = $urandom_range(1, HEADER_BYTES - 1);
        default: begin
          for (int i = 0; i < 8; i++) h[i] = $urandom;
          total = $urandom_range(1, 64);
        end
      endcase
    end
    send_image(h, total, nf_cell, 1'b0, ST_OK);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic reg_readback(input logic [2:0] idx, input logic [31:0] want,
                              input logic [31:0] mask);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    if ((got & mask) != (want & mask)) note_mismatch("register readback", got, want);
  endtask

  task automatic apply_cfg(input cfg_t c);
    settle();
    reg_write(REG_MAGIC, c.magic_word);
    reg_write(REG_VERSION, c.format_version);
    reg_write(REG_MIN_SIDE, 32'(c.min_side));
    reg_write(REG_MAX_SIDE, 32'(c.max_side));
    reg_write(REG_MAX_LAYERS, 32'(c.max_layers));
    reg_readback(REG_MAGIC, c.magic_word, 32'hFFFF_FFFF);
    reg_readback(REG_VERSION, c.format_version, 32'hFFFF_FFFF);
    reg_readback(REG_MIN_SIDE, 32'(c.min_side), 32'h0000_07FF);
    reg_readback(REG_MAX_SIDE, 32'(c.max_side), 32'h0000_07FF);
    reg_readback(REG_MAX_LAYERS, 32'(c.max_layers), 32'h0000_000F);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    cur_cfg = c;
  endtask

  initial begin
    cfg_t             dflt;
    cfg_t             wide;
    cfg_t             crossed;
    cfg_t             c;
    logic [7:0][31:0] good2;
    image_row_t       row;
    int               total;
    int               start;
    int               imgs;
    int               lo;
    int               hi;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    bytes_sent = 0;
    cycles = 0;
    send_idle = 10;
    recv_stall = 10;
    dflt = make_cfg(32'd0, 32'd1, 2, 255, 8);
    wide = make_cfg(32'hFFFF_FFFF, 32'd0, 1, 1024, 15);
    crossed = make_cfg(32'd0, 32'd1, 9, 8, 8);
    cur_cfg = dflt;
    clear_scan();

    good2 = pack_header(0, 1, 32'h0001_0000, 2, 0, 0, 0, 0);
    add_row(dflt, good2, 0, 0, -1, 1, ST_OK);
    add_row(dflt, good2, 1, 0, -1, 1, ST_SMALL);
    add_row(dflt, pack_header(32'hDEAD_BEEF, 7, 32'h1234, 0, 99, 1, 1, 1), 31, 0, -1, 1,
            ST_SMALL);
    add_row(dflt, good2, 32, 0, -1, 1, ST_SIZE);
    add_row(dflt, pack_header(1, 2, 32'h0001_0000, 2, 0, 0, 0, 0), 48, 0, -1, 1, ST_MAGIC);
    add_row(dflt, pack_header(0, 32'hFFFF_FFFF, 32'h0001_0000, 2, 0, 0, 0, 0), 48, 0, -1, 1,
            ST_VERSION);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 1, 0, 0, 0, 0), 48, 0, -1, 1, ST_SIDE);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 256, 0, 0, 0, 0), 48, 0, -1, 1, ST_SIDE);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 32'h8000_0002, 0, 0, 0, 0), 48, 0, -1, 1,
            ST_SIDE);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 2, 9, 0, 0, 0), 48, 0, -1, 1, ST_LAYERS);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 2, 32'h10, 0, 0, 0), 48, 0, -1, 1,
            ST_LAYERS);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 2, 0, 32'h8000_0000, 0, 0), 48, 0, -1, 1,
            ST_FLAGS);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 2, 0, 0, 1, 0), 48, 0, -1, 1, ST_RESERVED);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 2, 0, 0, 0, 32'h8000_0000), 48, 0, -1, 1,
            ST_RESERVED);
    add_row(dflt, pack_header(0, 1, 32'h0001_8000, 2, 0, 0, 0, 0), 48, 0, -1, 1, ST_ID);
    add_row(dflt, pack_header(0, 1, 32'h0001_0000, 0, 15, 0, 0, 0), 48, 0, -1, 1, ST_SIDE);
    add_row(dflt, pack_header(0, 1, 32'h0000_0001, 2, 0, 1, 0, 0), 48, 0, -1, 1, ST_FLAGS);
    add_row(dflt, good2, 0, 0, 3, 1, ST_NONFINITE);
    add_row(dflt, good2, 0, 1, 3, 1, ST_SIZE);
    add_row(dflt, good2, 0, 1, -1, 1, ST_SIZE);
    add_row(dflt, good2, 0, -1, -1, 1, ST_SIZE);
    add_row(dflt, pack_header(0, 1, 32'hFFFF_0000, 3, 8, 0, 0, 0), 0, 0, -1, 0, ST_OK);
    add_row(wide, pack_header(32'hFFFF_FFFF, 0, 32'hABCD_0000, 1, 15, 0, 0, 0), 0, 0, -1, 0,
            ST_OK);
    add_row(wide, pack_header(32'hFFFF_FFFF, 0, 32'h0005_0000, 1024, 15, 0, 0, 0), 64, 0, -1,
            1, ST_SIZE);
    add_row(wide, pack_header(32'hFFFF_FFFF, 0, 32'h0005_0000, 1025, 0, 0, 0, 0), 48, 0, -1,
            1, ST_SIDE);
    add_row(wide, pack_header(32'hFFFF_FFFF, 0, 32'h0005_0000, 0, 0, 0, 0, 0), 48, 0, -1, 1,
            ST_SIDE);
    add_row(crossed, pack_header(0, 1, 32'h0001_0000, 8, 0, 0, 0, 0), 48, 0, -1, 1, ST_SIDE);
    add_row(crossed, pack_header(0, 1, 32'h0001_0000, 9, 0, 0, 0, 0), 48, 0, -1, 1, ST_SIDE);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // The first rows run with the register values left by reset.
    foreach (image_rows[i]) begin
      row = image_rows[i];
      if (row.cfg != cur_cfg) apply_cfg(row.cfg);
      total = row.len;
      if (total == 0)
        total = HEADER_BYTES + int'(row.hdr[HW_SIDE]) * int'(row.hdr[HW_SIDE]) *
                (4 + int'(row.hdr[HW_LAYERS])) + row.len_adj;
      send_image(row.hdr, total, row.nf_cell, row.typed, row.st);
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 60; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 60; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      case (ph)
        1: c = make_cfg(32'hFFFF_FFFF, 32'd0, 1, 1024, 15);
        4: c = make_cfg($urandom, $urandom, 1024, 1024, 0);
        6: c = make_cfg($urandom, $urandom, 6, 3, $urandom_range(0, 15));
        8: c = make_cfg(32'd0, 32'hFFFF_FFFF, 1, 1, 0);
        default: begin
          lo = $urandom_range(1, 4);
          hi = lo + $urandom_range(0, 1020);
          if (hi > 1024) hi = 1024;
          c = make_cfg($urandom, $urandom, lo, hi, $urandom_range(0, 15));
        end
      endcase
      apply_cfg(c);
      start = bytes_sent;
      imgs = 0;
      while (bytes_sent - start < 40 || imgs < 1) begin
        random_image();
        imgs++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
